[src/icf_pkg.sv]
// Shared constants, types and helper functions of the integer to ASCII formatter.
package icf_pkg;

  localparam int MaxWidth   = 24;
  localparam int ValW       = 64;
  localparam int FldW       = 5;
  localparam int CmdW       = 2;
  localparam int CharW      = 8;
  localparam int DecDigits  = 20;
  localparam int HexDigits  = ValW / 4;
  localparam int BcdW       = 4 * DecDigits;
  localparam int CntW       = $clog2(MaxWidth + 2);
  localparam int DigW       = $clog2(DecDigits + 1);
  localparam int StepW      = $clog2(ValW);
  localparam int QueueDepth = 2;
  localparam int PtrW       = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam int ValueLsb   = 0;
  localparam int WidthLsb   = ValueLsb + ValW;
  localparam int PointLsb   = WidthLsb + FldW;
  localparam int InDataBits = PointLsb + FldW;
  localparam int InTdataW   = ((InDataBits + 7) / 8) * 8;

  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChMinus = 8'h2d;
  localparam logic [CharW-1:0] ChDot   = 8'h2e;
  localparam logic [CharW-1:0] ChLowA  = 8'h61;

  typedef enum logic [CmdW-1:0] {
    CmdUdec = 2'd0,
    CmdSdec = 2'd1,
    CmdHex  = 2'd2,
    CmdFix  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [ValW-1:0]     mag;
    logic [CntW-1:0]     width;
    logic [CntW-1:0]     point;
    logic                neg;
  } job_t;

  function automatic logic [CharW-1:0] digit_char(input logic [3:0] d);
    logic [CharW-1:0] c;
    if (d < 4'd10) begin
      c = ChZero + CharW'(d);
    end else begin
      c = ChLowA + CharW'(d - 4'd10);
    end
    return c;
  endfunction

endpackage

[src/icf_front.sv]
// Front end: accepts input transactions, saturates width and point, and takes the magnitude.
module icf_front (
  input  logic                         s_valid_i,
  output logic                         s_ready_o,
  input  logic [icf_pkg::InTdataW-1:0] s_data_i,
  input  logic [icf_pkg::CmdW-1:0]     s_user_i,
  input  logic                         full_i,
  output logic                         push_o,
  output icf_pkg::job_t                job_o
);

  logic [icf_pkg::ValW-1:0] value;
  logic [icf_pkg::CntW-1:0] width_raw;
  logic [icf_pkg::CntW-1:0] point_raw;
  icf_pkg::cmd_e            cmd;
  logic                     neg;

  assign s_ready_o = !full_i;
  assign push_o    = s_valid_i && !full_i;

  always_comb begin
    cmd       = icf_pkg::cmd_e'(s_user_i);
    value     = s_data_i[icf_pkg::ValueLsb +: icf_pkg::ValW];
    width_raw = icf_pkg::CntW'(s_data_i[icf_pkg::WidthLsb +: icf_pkg::FldW]);
    point_raw = icf_pkg::CntW'(s_data_i[icf_pkg::PointLsb +: icf_pkg::FldW]);
    neg       = (cmd == icf_pkg::CmdSdec) && value[icf_pkg::ValW-1];

    job_o.cmd   = cmd;
    job_o.neg   = neg;
    job_o.mag   = neg ? (~value + icf_pkg::ValW'(1)) : value;
    job_o.width = (width_raw > icf_pkg::CntW'(icf_pkg::MaxWidth)) ?
                  icf_pkg::CntW'(icf_pkg::MaxWidth) : width_raw;
    job_o.point = (point_raw > icf_pkg::CntW'(icf_pkg::MaxWidth - 1)) ?
                  icf_pkg::CntW'(icf_pkg::MaxWidth - 1) : point_raw;
  end

endmodule

[src/icf_fifo.sv]
// Short job queue between the front end and the conversion back end.
module icf_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  icf_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output icf_pkg::job_t job_o
);

  icf_pkg::job_t             mem_q [icf_pkg::QueueDepth];
  logic [icf_pkg::PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [icf_pkg::PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [icf_pkg::QCntW-1:0] count_q, count_d;

  assign full_o  = (count_q == icf_pkg::QCntW'(icf_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == icf_pkg::PtrW'(icf_pkg::QueueDepth - 1)) ?
                 '0 : wr_ptr_q + icf_pkg::PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == icf_pkg::PtrW'(icf_pkg::QueueDepth - 1)) ?
                 '0 : rd_ptr_q + icf_pkg::PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + icf_pkg::QCntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - icf_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

[src/icf_back.sv]
// Back end: serial binary to BCD conversion for the decimal modes, digit trimming and character emission.
module icf_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      empty_i,
  input  icf_pkg::job_t             job_i,
  output logic                      pop_o,
  output logic                      m_valid_o,
  input  logic                      m_ready_i,
  output logic [icf_pkg::CharW-1:0] m_char_o,
  output logic                      m_last_o
);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StConv = 5'b00010,
    StNorm = 5'b00100,
    StPlan = 5'b01000,
    StEmit = 5'b10000
  } state_e;

  state_e                     state_q, state_d;
  icf_pkg::cmd_e              cmd_q, cmd_d;
  logic                       neg_q, neg_d;
  logic [icf_pkg::CntW-1:0]   width_q, width_d;
  logic [icf_pkg::CntW-1:0]   point_q, point_d;
  logic [icf_pkg::ValW-1:0]   bin_q, bin_d;
  logic [icf_pkg::BcdW-1:0]   dig_q, dig_d;
  logic [icf_pkg::BcdW-1:0]   adj;
  logic [icf_pkg::StepW-1:0]  step_q, step_d;
  logic [icf_pkg::DigW-1:0]   cnt_q, cnt_d;
  logic                       sign_q, sign_d;
  logic [icf_pkg::CntW-1:0]   z1_q, z1_d;
  logic [icf_pkg::CntW-1:0]   a_q, a_d;
  logic                       dot_q, dot_d;
  logic [icf_pkg::CntW-1:0]   z2_q, z2_d;
  logic [icf_pkg::CntW-1:0]   b_q, b_d;
  logic [icf_pkg::CntW-1:0]   rem_q, rem_d;
  logic                       out_valid_q, out_valid_d;
  logic [icf_pkg::CharW-1:0]  out_char_q, out_char_d;
  logic                       out_last_q, out_last_d;

  logic [3:0]                 top;
  logic [icf_pkg::CntW-1:0]   c;
  logic [icf_pkg::CntW-1:0]   pad;
  logic [icf_pkg::DigW-1:0]   hex_target;
  logic                       drop;
  logic                       can_emit;

  assign m_valid_o = out_valid_q;
  assign m_char_o  = out_char_q;
  assign m_last_o  = out_last_q;
  assign top       = dig_q[icf_pkg::BcdW-1 -: 4];
  assign c         = icf_pkg::CntW'(cnt_q);
  assign can_emit  = !out_valid_q || m_ready_i;
  assign pad       = (width_q > c) ? width_q - c : '0;

  always_comb begin
    for (int k = 0; k < icf_pkg::DecDigits; k++) begin
      adj[4*k +: 4] = (dig_q[4*k +: 4] >= 4'd5) ? dig_q[4*k +: 4] + 4'd3 : dig_q[4*k +: 4];
    end
  end

  always_comb begin
    if (width_q > icf_pkg::CntW'(icf_pkg::HexDigits)) begin
      hex_target = icf_pkg::DigW'(icf_pkg::HexDigits);
    end else begin
      hex_target = icf_pkg::DigW'(width_q);
    end
    if ((cmd_q == icf_pkg::CmdHex) && (width_q != '0)) begin
      drop = (cnt_q > hex_target);
    end else begin
      drop = (top == 4'd0) && (cnt_q > icf_pkg::DigW'(1));
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    neg_d       = neg_q;
    width_d     = width_q;
    point_d     = point_q;
    bin_d       = bin_q;
    dig_d       = dig_q;
    step_d      = step_q;
    cnt_d       = cnt_q;
    sign_d      = sign_q;
    z1_d        = z1_q;
    a_d         = a_q;
    dot_d       = dot_q;
    z2_d        = z2_q;
    b_d         = b_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q && !m_ready_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    pop_o       = 1'b0;

    case (state_q)
      StIdle: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          cmd_d   = job_i.cmd;
          neg_d   = job_i.neg;
          width_d = job_i.width;
          point_d = job_i.point;
          bin_d   = job_i.mag;
          step_d  = '0;
          if (job_i.cmd == icf_pkg::CmdHex) begin
            dig_d   = {job_i.mag, (icf_pkg::BcdW - icf_pkg::ValW)'(0)};
            cnt_d   = icf_pkg::DigW'(icf_pkg::HexDigits);
            state_d = StNorm;
          end else begin
            dig_d   = '0;
            state_d = StConv;
          end
        end
      end
      StConv: begin
        dig_d  = {adj[icf_pkg::BcdW-2:0], bin_q[icf_pkg::ValW-1]};
        bin_d  = {bin_q[icf_pkg::ValW-2:0], 1'b0};
        step_d = step_q + icf_pkg::StepW'(1);
        if (step_q == icf_pkg::StepW'(icf_pkg::ValW - 1)) begin
          cnt_d   = icf_pkg::DigW'(icf_pkg::DecDigits);
          state_d = StNorm;
        end
      end
      StNorm: begin
        if (drop) begin
          dig_d = {dig_q[icf_pkg::BcdW-5:0], 4'd0};
          cnt_d = cnt_q - icf_pkg::DigW'(1);
        end else begin
          state_d = StPlan;
        end
      end
      StPlan: begin
        sign_d = 1'b0;
        z1_d   = '0;
        a_d    = '0;
        dot_d  = 1'b0;
        z2_d   = '0;
        b_d    = '0;
        case (cmd_q)
          icf_pkg::CmdUdec: begin
            z1_d = pad;
            a_d  = c;
          end
          icf_pkg::CmdSdec: begin
            sign_d = neg_q;
            a_d    = c;
          end
          icf_pkg::CmdHex: begin
            a_d = c;
          end
          icf_pkg::CmdFix: begin
            dot_d = 1'b1;
            if (c > point_q) begin
              z1_d = pad;
              a_d  = c - point_q;
              b_d  = point_q;
            end else begin
              z1_d = (width_q <= point_q) ? icf_pkg::CntW'(1) : width_q - point_q;
              z2_d = point_q - c;
              b_d  = c;
            end
          end
          default: begin
            a_d = c;
          end
        endcase
        rem_d   = z1_d + a_d + z2_d + b_d + icf_pkg::CntW'(sign_d) + icf_pkg::CntW'(dot_d);
        state_d = StEmit;
      end
      StEmit: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          out_last_d  = (rem_q == icf_pkg::CntW'(1));
          rem_d       = rem_q - icf_pkg::CntW'(1);
          if (sign_q) begin
            out_char_d = icf_pkg::ChMinus;
            sign_d     = 1'b0;
          end else if (z1_q != '0) begin
            out_char_d = icf_pkg::ChZero;
            z1_d       = z1_q - icf_pkg::CntW'(1);
          end else if (a_q != '0) begin
            out_char_d = icf_pkg::digit_char(top);
            a_d        = a_q - icf_pkg::CntW'(1);
            dig_d      = {dig_q[icf_pkg::BcdW-5:0], 4'd0};
          end else if (dot_q) begin
            out_char_d = icf_pkg::ChDot;
            dot_d      = 1'b0;
          end else if (z2_q != '0) begin
            out_char_d = icf_pkg::ChZero;
            z2_d       = z2_q - icf_pkg::CntW'(1);
          end else begin
            out_char_d = icf_pkg::digit_char(top);
            b_d        = b_q - icf_pkg::CntW'(1);
            dig_d      = {dig_q[icf_pkg::BcdW-5:0], 4'd0};
          end
          if (rem_q == icf_pkg::CntW'(1)) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    neg_q      <= neg_d;
    width_q    <= width_d;
    point_q    <= point_d;
    bin_q      <= bin_d;
    dig_q      <= dig_d;
    step_q     <= step_d;
    cnt_q      <= cnt_d;
    sign_q     <= sign_d;
    z1_q       <= z1_d;
    a_q        <= a_d;
    dot_q      <= dot_d;
    z2_q       <= z2_d;
    b_q        <= b_d;
    rem_q      <= rem_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

endmodule

[src/integer_to_ascii_formatter_core.sv]
// Top level of the integer to ASCII formatter.
// Each input transaction carries a 64-bit value, a mode in tuser, and a width and point
// position; the block answers with one output transaction per ASCII character, tlast on the
// final one. Decimal modes run a shift-and-add-3 converter, then strip leading zero digits;
// a planning state follows, and the characters (1 to 25) go out one per cycle while the
// output is not stalled. The serial converter handles one item at a time. A two-entry
// queue in front of the converter keeps accepting items while a conversion runs, and the
// output register holds a character while the next one is being prepared.
module integer_to_ascii_formatter_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [icf_pkg::InTdataW-1:0] s_axis_tdata_i,  // value, width, point
  input  logic [icf_pkg::CmdW-1:0]     s_axis_tuser_i,  // command
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [icf_pkg::CharW-1:0]    m_axis_tdata_o,  // character
  output logic                         m_axis_tlast_o
);

  icf_pkg::job_t push_job;
  icf_pkg::job_t head_job;
  logic          push;
  logic          pop;
  logic          full;
  logic          empty;

  icf_front u_front (
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_data_i  (s_axis_tdata_i),
    .s_user_i  (s_axis_tuser_i),
    .full_i    (full),
    .push_o    (push),
    .job_o     (push_job)
  );

  icf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (head_job)
  );

  icf_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .empty_i   (empty),
    .job_i     (head_job),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_char_o  (m_axis_tdata_o),
    .m_last_o  (m_axis_tlast_o)
  );

endmodule

[src/icf_checker.sv]
// Port-level checker for the integer to ASCII formatter, bound to the top level.
module icf_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid_i,
  input logic                      s_axis_tready_o,
  input logic                      m_axis_tvalid_o,
  input logic                      m_axis_tready_i,
  input logic [icf_pkg::CharW-1:0] m_axis_tdata_o,
  input logic                      m_axis_tlast_o
);

  logic [2:0] pending_q, pending_d;
  logic       in_acc;
  logic       run_done;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign run_done = m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o;

  always_comb begin
    pending_d = pending_q;
    if (in_acc && !run_done) begin
      pending_d = pending_q + 3'd1;
    end else if (run_done && !in_acc) begin
      pending_d = pending_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("Output transaction dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("Output payload changed while stalled.");

  a_out_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> pending_q != 3'd0)
    else $error("Character shown with no accepted item outstanding.");

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd4)
    else $error("More items outstanding than the queue and back end can hold.");

  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (m_axis_tdata_o >= 8'h30 && m_axis_tdata_o <= 8'h39) ||
      (m_axis_tdata_o >= 8'h61 && m_axis_tdata_o <= 8'h66) ||
      m_axis_tdata_o == 8'h2d || m_axis_tdata_o == 8'h2e)
    else $error("Character outside the digit, sign and point set.");

endmodule

bind integer_to_ascii_formatter_core icf_checker u_icf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
